// File: design/hls_lightness_saturation_adjust_assert.svh
// ----------------------------------------------------------------------------
// HLS adjuster assertion macros
// Concurrent assertion wrappers; they compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef HLS_LIGHTNESS_SATURATION_ADJUST_ASSERT_SVH
`define HLS_LIGHTNESS_SATURATION_ADJUST_ASSERT_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define HLSA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hls adjust: implication check failed");
// The condition must never be true.
`define HLSA_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("hls adjust: forbidden condition seen");
`else
`define HLSA_ASSERT_IMP(lbl, ante, cons)
`define HLSA_ASSERT_NEVER(lbl, cond)
`endif

`endif

// File: design/hlsa_pkg.sv
// ----------------------------------------------------------------------------
// HLS adjuster package
// Shared types, fixed-point constants and small arithmetic helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package hlsa_pkg;

	localparam int NUM_STAGES = 14;
	typedef logic [NUM_STAGES:1] stage_en_t;

	localparam logic REG_LIGHTNESS  = 1'b0;
	localparam logic REG_SATURATION = 1'b1;

	localparam logic signed [7:0] PCT_MAX = 8'sd100;
	localparam logic signed [7:0] PCT_MIN = -8'sd100;

	localparam int DIV_STEPS_PER_STAGE = 4;

	// Reciprocals for exact truncating division of bounded values.
	localparam logic [16:0] RECIP_100 = 17'd41944;   // 2^22 / 100, rounded up
	localparam logic [16:0] RECIP_360 = 17'd93207;   // 2^25 / 360, rounded up
	localparam logic [17:0] RECIP_255 = 18'd131587;  // 2^25 / 255, rounded up
	localparam logic [23:0] RECIP_60  = 24'd8947849; // 2^29 / 60, rounded up

	localparam logic [24:0] FULL_DEG = 25'd23592960; // 360 degrees in 16.16
	localparam logic [19:0] BASE_RED   = 20'd393216;
	localparam logic [19:0] BASE_GREEN = 20'd131072;
	localparam logic [19:0] BASE_BLUE  = 20'd262144;

	localparam logic signed [26:0] FULL_S  = 27'sd23592960;
	localparam logic signed [26:0] DEG60_S  = 27'sd3932160;
	localparam logic signed [26:0] DEG180_S = 27'sd11796480;
	localparam logic signed [26:0] DEG240_S = 27'sd15728640;

	localparam logic signed [23:0] OFS_RED   = 24'sd7864320;
	localparam logic signed [23:0] OFS_GREEN = 24'sd0;
	localparam logic signed [23:0] OFS_BLUE  = -24'sd7864320;

	localparam logic [1:0] SEG_RISE = 2'd0;
	localparam logic [1:0] SEG_HIGH = 2'd1;
	localparam logic [1:0] SEG_FALL = 2'd2;
	localparam logic [1:0] SEG_LOW  = 2'd3;

	typedef struct packed {
		logic [7:0]  rem;
		logic [16:0] quo;
	} div_state_t;

	typedef struct packed {
		logic [7:0] light;
		logic       bmax;
		logic       gmax;
		logic       dz;
	} fwd_side_t;

	typedef struct packed {
		logic [1:0]  seg;
		logic [21:0] rp;
	} chan_pos_t;

	function automatic logic signed [7:0] pct_clamp(input logic [7:0] raw);
		logic signed [7:0] s;
		s = signed'(raw);
		if (s < PCT_MIN) return PCT_MIN;
		if (s > PCT_MAX) return PCT_MAX;
		return s;
	endfunction

	function automatic logic [7:0] div100(input logic [14:0] n);
		logic [31:0] p;
		p = 32'(n) * 32'(RECIP_100);
		return p[29:22];
	endfunction

	// Numerator of the percent move: distance to white or the scaled value.
	function automatic logic [14:0] pct_num(input logic [7:0] v, input logic signed [7:0] p);
		logic [7:0] up;
		logic signed [7:0] dn;
		logic [14:0] a;
		logic [14:0] b;
		up = 8'd255 - v;
		dn = p + 8'sd100;
		a = '0;
		b = '0;
		if (p > 8'sd0) begin
			a = {7'b0, up};
			b = {8'b0, p[6:0]};
		end else if (p < 8'sd0) begin
			a = {7'b0, v};
			b = {8'b0, dn[6:0]};
		end
		return a * b;
	endfunction

	function automatic logic [7:0] pct_apply(input logic [7:0] v, input logic signed [7:0] p,
			input logic [14:0] num);
		logic [7:0] q;
		q = div100(num);
		if (p > 8'sd0) return v + q;
		if (p < 8'sd0) return q;
		return v;
	endfunction

	function automatic div_state_t div_steps(input div_state_t st, input logic [7:0] den);
		div_state_t nx;
		logic [8:0] t;
		nx = st;
		for (int i = 0; i < DIV_STEPS_PER_STAGE; i++) begin
			t = {nx.rem, 1'b0};
			if (t >= {1'b0, den}) begin
				nx.rem = 8'(t - {1'b0, den});
				nx.quo = {nx.quo[15:0], 1'b1};
			end else begin
				nx.rem = t[7:0];
				nx.quo = {nx.quo[15:0], 1'b0};
			end
		end
		return nx;
	endfunction

	// Wraps an offset hue into one turn and picks the ramp segment.
	function automatic chan_pos_t chan_pos(input logic [24:0] hu, input logic signed [23:0] ofs);
		logic signed [26:0] r;
		chan_pos_t p;
		r = signed'({2'b0, hu}) + 27'(ofs);
		if (r > FULL_S) r = r - FULL_S;
		else if (r < 27'sd0) r = r + FULL_S;
		if (r < DEG60_S) begin
			p.seg = SEG_RISE;
			p.rp = 22'(r);
		end else if (r < DEG180_S) begin
			p.seg = SEG_HIGH;
			p.rp = '0;
		end else if (r < DEG240_S) begin
			p.seg = SEG_FALL;
			p.rp = 22'(DEG240_S - r);
		end else begin
			p.seg = SEG_LOW;
			p.rp = '0;
		end
		return p;
	endfunction

endpackage

`default_nettype wire

// File: design/hlsa_div.sv
// ----------------------------------------------------------------------------
// HLS adjuster divider lane
// Pipelined long division (num << 16) / den for num <= den, four bits a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module hlsa_div (
	input  logic        clk,
	input  logic [3:0]  en,
	input  logic [7:0]  num,
	input  logic [7:0]  den,
	output logic [16:0] quo
);

	hlsa_pkg::div_state_t st_s [1:4];
	logic [7:0]           den_s [1:3];
	hlsa_pkg::div_state_t st_in [1:4];
	logic [7:0]           den_in [1:4];

	// The top quotient bit is set only when numerator equals divisor.
	assign st_in[1]  = {((num == den) ? 8'd0 : num), {16'b0, (num == den)}};
	assign den_in[1] = den;

	for (genvar k = 2; k <= 4; k++) begin : g_link
		assign st_in[k]  = st_s[k-1];
		assign den_in[k] = den_s[k-1];
	end

	for (genvar k = 1; k <= 4; k++) begin : g_stage
		always_ff @(posedge clk) begin
			if (en[k-1]) begin
				st_s[k] <= hlsa_pkg::div_steps(st_in[k], den_in[k]);
			end
		end
	end

	// The divisor only travels as far as the last stage that needs it.
	for (genvar k = 1; k <= 3; k++) begin : g_den
		always_ff @(posedge clk) begin
			if (en[k-1]) begin
				den_s[k] <= den_in[k];
			end
		end
	end

	assign quo = st_s[4].quo;

endmodule

`default_nettype wire

// File: design/hlsa_fwd.sv
// ----------------------------------------------------------------------------
// HLS adjuster forward path
// RGB to hue, lightness, saturation, then the percent moves (stages 1 to 8).
// ----------------------------------------------------------------------------
`default_nettype none

module hlsa_fwd (
	input  logic                     clk,
	input  hlsa_pkg::stage_en_t      en,
	input  logic [7:0]               red,
	input  logic [7:0]               green,
	input  logic [7:0]               blue,
	input  logic signed [7:0]        l_pct,
	input  logic signed [7:0]        s_pct,
	output logic [7:0]               hue,
	output logic [7:0]               light,
	output logic [7:0]               sat
);

	logic [7:0] mx, mn, dd, qd;
	logic [8:0] sm;

	always_comb begin
		mx = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		mn = red;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		dd = mx - mn;
		sm = {1'b0, mx} + {1'b0, mn};
		qd = (sm <= 9'd255) ? sm[7:0] : 8'(9'd510 - sm);
	end

	logic [7:0] xr_s1, xg_s1, xb_s1, d_s1, q_s1;
	hlsa_pkg::fwd_side_t side_s1, side_s2, side_s3, side_s4, side_s5;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			xr_s1 <= mx - red;
			xg_s1 <= mx - green;
			xb_s1 <= mx - blue;
			d_s1 <= dd;
			q_s1 <= qd;
			side_s1.light <= sm[8:1];
			side_s1.bmax <= (blue == mx);
			side_s1.gmax <= (green == mx);
			side_s1.dz <= (dd == 8'd0);
		end
	end

	logic [16:0] nr, ng, nb, ns;

	hlsa_div u_div_r (.clk(clk), .en(en[5:2]), .num(xr_s1), .den(d_s1), .quo(nr));
	hlsa_div u_div_g (.clk(clk), .en(en[5:2]), .num(xg_s1), .den(d_s1), .quo(ng));
	hlsa_div u_div_b (.clk(clk), .en(en[5:2]), .num(xb_s1), .den(d_s1), .quo(nb));
	hlsa_div u_div_s (.clk(clk), .en(en[5:2]), .num(d_s1), .den(q_s1), .quo(ns));

	always_ff @(posedge clk) begin
		if (en[2]) side_s2 <= side_s1;
		if (en[3]) side_s3 <= side_s2;
		if (en[4]) side_s4 <= side_s3;
		if (en[5]) side_s5 <= side_s4;
	end

	// Stage 6: hue in 16.16 degrees, saturation byte, lightness numerator.
	logic [19:0] base;
	logic [25:0] hue60;
	logic [24:0] hue_w, sprod;
	logic [8:0]  sfix;

	always_comb begin
		if (side_s5.bmax) base = hlsa_pkg::BASE_BLUE + 20'(ng) - 20'(nr);
		else if (side_s5.gmax) base = hlsa_pkg::BASE_GREEN + 20'(nr) - 20'(nb);
		else base = hlsa_pkg::BASE_RED + 20'(nb) - 20'(ng);
		hue60 = {base, 6'b0} - {4'b0, base, 2'b0};
		if (hue60 > 26'(hlsa_pkg::FULL_DEG)) hue_w = 25'(hue60 - 26'(hlsa_pkg::FULL_DEG));
		else hue_w = 25'(hue60);
		sprod = {ns, 8'b0} - {8'b0, ns};
		sfix = sprod[24:16];
	end

	logic [24:0] hue_s6;
	logic [7:0]  s_s6, l_s6;
	logic [14:0] lnum_s6;
	logic        dz_s6;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			hue_s6 <= hue_w;
			s_s6 <= side_s5.dz ? 8'd0 : (sfix[8] ? 8'd255 : sfix[7:0]);
			l_s6 <= side_s5.light;
			lnum_s6 <= hlsa_pkg::pct_num(side_s5.light, l_pct);
			dz_s6 <= side_s5.dz;
		end
	end

	// Stage 7: hue scaled by 255, lightness finished, saturation numerator.
	logic [32:0] hprod;
	assign hprod = {hue_s6, 8'b0} - {8'b0, hue_s6};

	logic [16:0] hx_s7;
	logic [7:0]  l_s7, s_s7;
	logic [14:0] snum_s7;
	logic        dz_s7;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			hx_s7 <= hprod[32:16];
			l_s7 <= hlsa_pkg::pct_apply(l_s6, l_pct, lnum_s6);
			snum_s7 <= hlsa_pkg::pct_num(s_s6, s_pct);
			s_s7 <= s_s6;
			dz_s7 <= dz_s6;
		end
	end

	// Stage 8: hue byte by division by 360, saturation finished.
	logic [33:0] hq;
	assign hq = 34'(hx_s7) * 34'(hlsa_pkg::RECIP_360);

	logic [7:0] h_s8, l_s8, s_s8;

	always_ff @(posedge clk) begin
		if (en[8]) begin
			h_s8 <= dz_s7 ? 8'd0 : hq[32:25];
			l_s8 <= l_s7;
			s_s8 <= hlsa_pkg::pct_apply(s_s7, s_pct, snum_s7);
		end
	end

	assign hue = h_s8;
	assign light = l_s8;
	assign sat = s_s8;

endmodule

`default_nettype wire

// File: design/hlsa_back.sv
// ----------------------------------------------------------------------------
// HLS adjuster back path
// Hue, lightness, saturation back to RGB bytes (stages 9 to 14).
// ----------------------------------------------------------------------------
`default_nettype none

module hlsa_back (
	input  logic                clk,
	input  hlsa_pkg::stage_en_t en,
	input  logic [7:0]          hue,
	input  logic [7:0]          light,
	input  logic [7:0]          sat,
	output logic [7:0]          red,
	output logic [7:0]          green,
	output logic [7:0]          blue
);

	// Stage 9: x / 255 in 16.16 is 257 x plus a small correction.
	logic [16:0] a;
	logic [34:0] ar;

	assign a = 17'(hue) * 17'd360;
	assign ar = 35'(a) * 35'(hlsa_pkg::RECIP_255);

	logic [24:0] hu_s9, hu_s10;
	logic [16:0] lu_s9, sa_s9, lu_s10, sa_s10, t_s10;
	logic [7:0]  l_s9, l_s10;
	logic        gray_s9, gray_s10;

	always_ff @(posedge clk) begin
		if (en[9]) begin
			hu_s9 <= 25'(a) * 25'd257 + 25'(ar[33:25]);
			lu_s9 <= 17'(light) * 17'd257 + 17'(light == 8'd255);
			sa_s9 <= 17'(sat) * 17'd257 + 17'(sat == 8'd255);
			l_s9 <= light;
			gray_s9 <= (sat == 8'd0);
		end
	end

	logic [33:0] tp;
	assign tp = 34'(lu_s9) * 34'(sa_s9);

	always_ff @(posedge clk) begin
		if (en[10]) begin
			t_s10 <= tp[32:16];
			hu_s10 <= hu_s9;
			lu_s10 <= lu_s9;
			sa_s10 <= sa_s9;
			l_s10 <= l_s9;
			gray_s10 <= gray_s9;
		end
	end

	// Stage 11: the two ramp levels and each channel's place on the ramp.
	logic [17:0]        m2w;
	logic [16:0]        m2, m1;
	logic signed [18:0] m1s;

	always_comb begin
		if (l_s10 <= 8'd127) m2w = {1'b0, lu_s10} + {1'b0, t_s10};
		else m2w = {1'b0, lu_s10} + {1'b0, sa_s10} - {1'b0, t_s10};
		m2 = m2w[16:0];
		m1s = signed'({1'b0, lu_s10, 1'b0}) - signed'({2'b0, m2});
		m1 = (m1s < 19'sd0) ? 17'd0 : m1s[16:0];
	end

	logic [16:0]         m1_s11, m2_s11, dm_s11;
	hlsa_pkg::chan_pos_t pos_s11 [3];
	logic [7:0]          l_s11;
	logic                gray_s11;

	always_ff @(posedge clk) begin
		if (en[11]) begin
			m1_s11 <= m1;
			m2_s11 <= m2;
			dm_s11 <= m2 - m1;
			pos_s11[0] <= hlsa_pkg::chan_pos(hu_s10, hlsa_pkg::OFS_RED);
			pos_s11[1] <= hlsa_pkg::chan_pos(hu_s10, hlsa_pkg::OFS_GREEN);
			pos_s11[2] <= hlsa_pkg::chan_pos(hu_s10, hlsa_pkg::OFS_BLUE);
			l_s11 <= l_s10;
			gray_s11 <= gray_s10;
		end
	end

	// Stage 12: ramp product, scaled down by 2^16.
	logic [22:0] y_s12 [3];
	logic [1:0]  seg_s12 [3];
	logic [16:0] m1_s12, m2_s12;
	logic [7:0]  l_s12;
	logic        gray_s12;
	logic [38:0] yp [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			yp[c] = 39'(dm_s11) * 39'(pos_s11[c].rp);
		end
	end

	always_ff @(posedge clk) begin
		if (en[12]) begin
			for (int c = 0; c < 3; c++) begin
				y_s12[c] <= yp[c][38:16];
				seg_s12[c] <= pos_s11[c].seg;
			end
			m1_s12 <= m1_s11;
			m2_s12 <= m2_s11;
			l_s12 <= l_s11;
			gray_s12 <= gray_s11;
		end
	end

	// Stage 13: division by 60 and the channel level.
	logic [46:0] qp [3];
	logic [17:0] v [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			qp[c] = 47'(y_s12[c]) * 47'(hlsa_pkg::RECIP_60);
			case (seg_s12[c])
				hlsa_pkg::SEG_RISE, hlsa_pkg::SEG_FALL: v[c] = {1'b0, m1_s12} + qp[c][46:29];
				hlsa_pkg::SEG_HIGH: v[c] = {1'b0, m2_s12};
				default: v[c] = {1'b0, m1_s12};
			endcase
		end
	end

	logic [17:0] v_s13 [3];
	logic [7:0]  l_s13;
	logic        gray_s13;

	always_ff @(posedge clk) begin
		if (en[13]) begin
			for (int c = 0; c < 3; c++) begin
				v_s13[c] <= v[c];
			end
			l_s13 <= l_s12;
			gray_s13 <= gray_s12;
		end
	end

	// Stage 14: byte conversion, or gray at the lightness value.
	logic [25:0] bp [3];
	logic [7:0]  byt [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			bp[c] = {v_s13[c], 8'b0} - {8'b0, v_s13[c]};
			if (gray_s13) byt[c] = l_s13;
			else if (bp[c][25:24] != 2'b00) byt[c] = 8'd255;
			else byt[c] = bp[c][23:16];
		end
	end

	logic [7:0] out_s14 [3];

	always_ff @(posedge clk) begin
		if (en[14]) begin
			for (int c = 0; c < 3; c++) begin
				out_s14[c] <= byt[c];
			end
		end
	end

	assign red = out_s14[0];
	assign green = out_s14[1];
	assign blue = out_s14[2];

endmodule

`default_nettype wire

// File: design/hls_lightness_saturation_adjust.sv
// ----------------------------------------------------------------------------
// HLS lightness and saturation adjuster
// Converts an RGB pixel to hue, lightness and saturation, moves lightness and
// saturation by signed percentages, and converts the result back to RGB.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_stall    red_in, green_in, blue_in
// output    out        out_valid / out_stall  red_out, green_out, blue_out
// config    in         cfg_we                 cfg_index, cfg_data
//
// The block takes one pixel per clock while in_stall is low, and each result
// passes through the fourteen pipeline stages, of which the divider lanes
// of the forward path take four.
// Reset clears the stage valid bits and both percent registers to zero.
// A stalled output holds its pixel; earlier stages keep filling empty slots,
// so input stalls only once every stage holds a pixel.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hls_lightness_saturation_adjust_assert.svh"

module hls_lightness_saturation_adjust (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] red_in,
	input  logic [7:0] green_in,
	input  logic [7:0] blue_in,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] red_out,
	output logic [7:0] green_out,
	output logic [7:0] blue_out,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);

	// Percent registers hold the clamped value, so an out-of-range write acts
	// as the nearest limit from then on.
	logic signed [7:0] lp_q, sp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q <= '0;
			sp_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				hlsa_pkg::REG_LIGHTNESS: lp_q <= hlsa_pkg::pct_clamp(cfg_data);
				hlsa_pkg::REG_SATURATION: sp_q <= hlsa_pkg::pct_clamp(cfg_data);
				default: ;
			endcase
		end
	end

	// Each stage loads when it is empty or when the stage after it loads.
	// This lets bubbles close up behind a stalled output.
	localparam int NS = hlsa_pkg::NUM_STAGES;

	logic [NS:1]   vld_q;
	logic [NS:1]   vld_prev;
	logic [NS+1:1] rdy;

	assign rdy[NS+1] = ~out_stall;
	for (genvar k = 1; k <= NS; k++) begin : g_ready
		assign rdy[k] = ~vld_q[k] | rdy[k+1];
	end
	assign vld_prev = {vld_q[NS-1:1], in_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= NS; k++) begin
				if (rdy[k]) vld_q[k] <= vld_prev[k];
			end
		end
	end

	hlsa_pkg::stage_en_t en;
	assign en = rdy[NS:1];

	assign in_stall = ~rdy[1];
	assign out_valid = vld_q[NS];

	logic [7:0] hue, light, sat;

	// Forward path: stages 1 to 8, including the pipelined dividers that normalize
	// each channel by the chroma span and divide the span for the saturation.
	hlsa_fwd u_fwd (
		.clk   (clk),
		.en    (en),
		.red   (red_in),
		.green (green_in),
		.blue  (blue_in),
		.l_pct (lp_q),
		.s_pct (sp_q),
		.hue   (hue),
		.light (light),
		.sat   (sat)
	);

	// Back path: stages 9 to 14, ending in the output register.
	hlsa_back u_back (
		.clk   (clk),
		.en    (en),
		.hue   (hue),
		.light (light),
		.sat   (sat),
		.red   (red_out),
		.green (green_out),
		.blue  (blue_out)
	);

	// Input may only be held off when every stage is occupied.
	`HLSA_ASSERT_IMP(a_stall_only_full, in_stall, &vld_q)
	// With the output free, the whole pipeline moves and input is open.
	`HLSA_ASSERT_IMP(a_open_when_free, !out_stall, !in_stall)
	// The stored percentages never leave their clamped range.
	`HLSA_ASSERT_NEVER(a_lp_range, (lp_q > hlsa_pkg::PCT_MAX) || (lp_q < hlsa_pkg::PCT_MIN))
	`HLSA_ASSERT_NEVER(a_sp_range, (sp_q > hlsa_pkg::PCT_MAX) || (sp_q < hlsa_pkg::PCT_MIN))

endmodule

`default_nettype wire
